[hdl/mclfe_pkg.sv]
// shared types and constants for the multi-channel led fade engine
`default_nettype none

package mclfe_pkg;

  // fixed field widths
  localparam int LVL_W    = 12;
  localparam int CNT_W    = 17;
  localparam int LIM_W    = 16;
  localparam int CHAN_W   = 2;
  localparam int GRP_W    = 2;
  localparam int OUT_CH_W = 4;

  // output channel = group * 4 + channel
  localparam int GRP_SHIFT = 2;

  // saturation value of the per-channel step counter
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // parameter defaults
  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_FULL_SCALE = 4095;

  // request type codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // input transaction
  typedef struct packed {
    logic              req_type;
    logic [CHAN_W-1:0] channel;
    logic [LVL_W-1:0]  target_level;
    logic [LIM_W-1:0]  fade_steps;
    logic              gamma_enable;
    logic              constant_time;
  } req_t;

  // output transaction
  typedef struct packed {
    logic [OUT_CH_W-1:0] out_channel;
    logic [LVL_W-1:0]    duty_level;
    logic                gamma_flag;
    logic                last_update;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/multi_channel_led_fade_engine_core.sv]
// multi-channel led fade engine: per-channel fade state in ram, shared divider
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------
//   request  | in        | in_valid_i / in_ready_o | in_data_i
//   duty     | out       | out_valid_o/out_ready_i | out_data_o
//   config   | in        | cfg_we_i, no wait       | cfg_wdata_i
//
// a tick walks all channels through the ram one at a time, each moving
// channel needing read, evaluate, multiply, PROD_W divide steps of the
// shared restoring divider and a write back.
// reset marks every ram entry invalid at once; invalid entries read as idle.
// a stalled output holds the engine only when a further duty update is due.
`default_nettype none

module multi_channel_led_fade_engine_core #(
  parameter int CHANNELS   = mclfe_pkg::DEF_CHANNELS,
  parameter int FULL_SCALE = mclfe_pkg::DEF_FULL_SCALE
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire mclfe_pkg::req_t            in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output mclfe_pkg::rsp_t                 out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [mclfe_pkg::GRP_W-1:0] cfg_wdata_i
);

  import mclfe_pkg::*;

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SPAN_W = $clog2(FULL_SCALE + 1);
  localparam int PROD_W = CNT_W + SPAN_W;
  localparam int NV_W   = PROD_W + 2;
  localparam int DC_W   = $clog2(PROD_W);

  // per-channel fade entry
  typedef struct packed {
    logic [LVL_W-1:0] cur;
    logic [LVL_W-1:0] tgt;
    logic [LVL_W-1:0] st;
    logic [CNT_W-1:0] cnt;
    logic [LIM_W-1:0] lim;
    logic             gam;
    logic             done;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);
  localparam ent_t ENT_RST = '{cur: '0, tgt: '0, st: '0, cnt: '0, lim: '0,
                               gam: 1'b0, done: 1'b1};

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_APPLY,
    S_PUSH,
    S_FLUSH
  } state_e;

  state_e              state_q;
  req_t                req_q;
  logic [IDX_W-1:0]    ch_q;
  logic [GRP_W-1:0]    grp_q;
  logic                mode_q;
  logic [CHANNELS-1:0] vld_q;
  logic                vld_rd_q;
  logic [SPAN_W-1:0]   span_q;
  logic                zdiv_q;
  logic [PROD_W-1:0]   quo_q;
  logic [LIM_W:0]      rem_q;
  logic [DC_W-1:0]     dcnt_q;
  rsp_t                res_q;
  logic                res_vld_q;
  rsp_t                pend_q;
  logic                pend_vld_q;
  rsp_t                out_q;
  logic                out_vld_q;

  logic                ram_we;
  ent_t                ram_wdata;
  logic [ENT_W-1:0]    ram_rdata;
  ent_t                ent;
  logic                up;
  logic [LVL_W-1:0]    tgt_sat;
  logic [SPAN_W-1:0]   span;
  logic [OUT_CH_W-1:0] out_ch;
  logic                out_free;
  logic                out_load;
  logic                last_ch;
  logic [LIM_W:0]      div_r;
  logic                div_ge;
  logic signed [NV_W-1:0] st_s;
  logic signed [NV_W-1:0] tgt_s;
  logic signed [NV_W-1:0] cur_s;
  logic signed [NV_W-1:0] nv_raw;
  logic signed [NV_W-1:0] nv;
  logic                moved;
  logic [CNT_W-1:0]    cnt_inc;
  logic                set_retarget;
  logic                in_acc;

  mclfe_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CHANNELS),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (ram_wdata),
    .re_i    (state_q == S_READ),
    .raddr_i (ch_q),
    .rdata_o (ram_rdata)
  );

  // entry as read, never-written entries look like reset
  assign ent = vld_rd_q ? ent_t'(ram_rdata) : ENT_RST;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_vld_q || out_ready_i;
  assign last_ch     = (ch_q == IDX_W'(CHANNELS - 1));

  // output register takes the pending update
  assign out_load = out_free && pend_vld_q &&
                    (((state_q == S_PUSH) && res_vld_q) || (state_q == S_FLUSH));

  // request target saturated to full scale
  assign tgt_sat = (int'(req_q.target_level) > FULL_SCALE) ? LVL_W'(FULL_SCALE)
                                                           : req_q.target_level;

  assign out_ch = (OUT_CH_W'(grp_q) << GRP_SHIFT) + OUT_CH_W'(ch_q);
  assign up     = (ent.cur < ent.tgt);

  // span of the running fade
  always_comb begin
    span = SPAN_W'(FULL_SCALE);
    if (mode_q) begin
      if (up) begin
        span = (ent.tgt >= ent.st) ? SPAN_W'(ent.tgt - ent.st) : '0;
      end else begin
        span = (ent.st >= ent.tgt) ? SPAN_W'(ent.st - ent.tgt) : '0;
      end
    end
  end

  // one restoring divide step
  assign div_r  = {rem_q[LIM_W-1:0], quo_q[PROD_W-1]};
  assign div_ge = (div_r >= {1'b0, ent.lim});

  // new level from start and quotient, clamped at target
  assign st_s  = $signed({{(NV_W - LVL_W){1'b0}}, ent.st});
  assign tgt_s = $signed({{(NV_W - LVL_W){1'b0}}, ent.tgt});
  assign cur_s = $signed({{(NV_W - LVL_W){1'b0}}, ent.cur});

  always_comb begin
    if (zdiv_q) begin
      nv_raw = tgt_s;
    end else if (up) begin
      nv_raw = st_s + $signed({2'b00, quo_q});
    end else begin
      nv_raw = st_s - $signed({2'b00, quo_q});
    end
    nv = nv_raw;
    if (up && (nv_raw > tgt_s)) begin
      nv = tgt_s;
    end else if (!up && (nv_raw < tgt_s)) begin
      nv = tgt_s;
    end
    moved = up ? (nv > cur_s) : (nv < cur_s);
  end

  assign cnt_inc = (ent.cnt < CNT_MAX) ? (ent.cnt + 1'b1) : ent.cnt;

  // constant-rate fade extended further in the same direction
  assign set_retarget = !mode_q &&
                        (((ent.st < ent.tgt) && (ent.cur < tgt_sat)) ||
                         ((ent.st > ent.tgt) && (ent.cur > tgt_sat)));

  // ram write back
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ent;
    case (state_q)
      S_EVAL: begin
        if (req_q.req_type == REQ_TICK) begin
          if (ent.cur == ent.tgt) begin
            ram_we         = 1'b1;
            ram_wdata.done = 1'b1;
          end
        end else if (tgt_sat != ent.cur) begin
          if (!ent.done) begin
            ram_we        = set_retarget;
            ram_wdata.tgt = tgt_sat;
          end else begin
            ram_we        = 1'b1;
            ram_wdata.tgt = tgt_sat;
            ram_wdata.st  = ent.cur;
            ram_wdata.cnt = '0;
            ram_wdata.gam = req_q.gamma_enable;
            if (req_q.fade_steps == '0) begin
              ram_wdata.cur = tgt_sat;
            end else begin
              ram_wdata.lim  = req_q.fade_steps;
              ram_wdata.done = 1'b0;
            end
          end
        end
      end
      S_APPLY: begin
        ram_we        = 1'b1;
        ram_wdata.cnt = cnt_inc;
        if (moved) begin
          ram_wdata.cur = nv[LVL_W-1:0];
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer, result queue and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      req_q      <= '0;
      ch_q       <= '0;
      grp_q      <= '0;
      mode_q     <= 1'b0;
      vld_q      <= '0;
      vld_rd_q   <= 1'b0;
      span_q     <= '0;
      zdiv_q     <= 1'b0;
      quo_q      <= '0;
      rem_q      <= '0;
      dcnt_q     <= '0;
      res_q      <= '0;
      res_vld_q  <= 1'b0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      out_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        grp_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[ch_q] <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q <= in_data_i;
            if (in_data_i.req_type == REQ_TICK) begin
              ch_q    <= '0;
              state_q <= S_READ;
            end else begin
              mode_q <= in_data_i.constant_time;
              if (int'(in_data_i.channel) < CHANNELS) begin
                ch_q    <= IDX_W'(in_data_i.channel);
                state_q <= S_READ;
              end else begin
                state_q <= S_FLUSH;
              end
            end
          end
        end

        S_READ: begin
          vld_rd_q <= vld_q[ch_q];
          state_q  <= S_EVAL;
        end

        S_EVAL: begin
          res_q.out_channel <= out_ch;
          res_q.last_update <= 1'b0;
          if (req_q.req_type == REQ_TICK) begin
            res_q.gamma_flag <= ent.gam;
            span_q           <= span;
            zdiv_q           <= (ent.lim == '0);
            res_vld_q        <= 1'b0;
            if (ent.cur == ent.tgt) begin
              state_q <= S_PUSH;
            end else if (ent.lim == '0) begin
              state_q <= S_APPLY;
            end else begin
              state_q <= S_MUL;
            end
          end else begin
            // only a jump from an idle channel emits on a set request
            res_q.duty_level <= tgt_sat;
            res_q.gamma_flag <= req_q.gamma_enable;
            res_vld_q        <= (tgt_sat != ent.cur) && ent.done &&
                                (req_q.fade_steps == '0);
            state_q          <= S_PUSH;
          end
        end

        S_MUL: begin
          quo_q   <= PROD_W'(ent.cnt) * PROD_W'(span_q);
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          quo_q  <= {quo_q[PROD_W-2:0], div_ge};
          rem_q  <= div_ge ? (div_r - {1'b0, ent.lim}) : div_r;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DC_W'(PROD_W - 1)) begin
            state_q <= S_APPLY;
          end
        end

        S_APPLY: begin
          res_q.duty_level <= nv[LVL_W-1:0];
          res_vld_q        <= moved;
          state_q          <= S_PUSH;
        end

        S_PUSH: begin
          if (!res_vld_q || !pend_vld_q || out_free) begin
            if (res_vld_q) begin
              pend_q     <= res_q;
              pend_vld_q <= 1'b1;
              if (pend_vld_q) begin
                out_q <= pend_q;
              end
            end
            if ((req_q.req_type == REQ_TICK) && !last_ch) begin
              ch_q    <= ch_q + 1'b1;
              state_q <= S_READ;
            end else begin
              state_q <= S_FLUSH;
            end
          end
        end

        S_FLUSH: begin
          if (!pend_vld_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_q      <= '{out_channel: pend_q.out_channel,
                            duty_level:  pend_q.duty_level,
                            gamma_flag:  pend_q.gamma_flag,
                            last_update: 1'b1};
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // nothing may wait in the pending slot once a new request can enter
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_vld_q)
    else $error("pending duty update left behind at idle");

  // the divider only runs on a nonzero step limit
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (ent.lim != '0))
    else $error("divider running with zero divisor");

  // a tick always starts its walk at the first channel
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.req_type == REQ_TICK)) |=>
      ((state_q == S_READ) && (ch_q == '0)))
    else $error("tick did not start at channel zero");
`endif

endmodule

`default_nettype wire

[hdl/mclfe_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none

module mclfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
